/* hw/rtl/vbd_pkg.sv */
// ----------------------------------------------------------------------------
// vbd_pkg: shared types and codes for the varint / big-endian field decoder
// Field kind and status codes, and the input and result records.
// ----------------------------------------------------------------------------
`default_nettype none

package vbd_pkg;

    // field kinds, same coding as the func input
    localparam logic [2:0] KIND_U8      = 3'd0;
    localparam logic [2:0] KIND_U16     = 3'd1;
    localparam logic [2:0] KIND_U32     = 3'd2;
    localparam logic [2:0] KIND_U64     = 3'd3;
    localparam logic [2:0] KIND_VARINT  = 3'd4;
    localparam logic [2:0] KIND_VARLONG = 3'd5;

    // result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BOUNDS   = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

    // variable integer group handling
    localparam logic [7:0] GROUP_MASK          = 8'h7F;
    localparam logic [7:0] CONT_BIT            = 8'h80;
    localparam logic [7:0] VARINT_SHIFT_LIMIT  = 8'd35;
    localparam logic [7:0] VARLONG_SHIFT_LIMIT = 8'd70;

    localparam int IN_W  = 12;
    localparam int RES_W = 69;

    typedef struct packed {
        logic       packet_end;
        logic [2:0] func;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  kind;
        logic [63:0] value;
    } t_result;

endpackage

`default_nettype wire

/* hw/rtl/vbd_pipe_reg.sv */
// ----------------------------------------------------------------------------
// vbd_pipe_reg: one-deep pipeline register with valid/ready handshake
// Loads whenever empty or when the held transaction leaves in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vbd_pipe_reg #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [WIDTH-1:0]      o_data
);

    logic             r_valid;
    logic [WIDTH-1:0] r_data;

    // accept when empty or draining this cycle
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // hold payload until the next load
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/vbd_core.sv */
// ----------------------------------------------------------------------------
// vbd_core: per-byte field decode
// Holds the open field state and works out each byte's result in one pass.
// ----------------------------------------------------------------------------
`default_nettype none

module vbd_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_advance,
    input  wire vbd_pkg::t_in_item i_item,
    output logic                   o_res_valid,
    output vbd_pkg::t_result       o_result
);

    logic [63:0] r_acc;
    logic [3:0]  r_bytes;
    logic [2:0]  r_kind;
    logic [63:0] n_acc;
    logic [3:0]  n_bytes;
    logic [2:0]  n_kind;

    logic        start;
    logic        drop;
    logic [2:0]  kind;
    logic [3:0]  n_cnt;
    logic [63:0] acc_base;
    logic [63:0] acc_fixed;
    logic [63:0] acc_var;
    logic [63:0] group;
    logic [6:0]  shift;
    logic [7:0]  shift_end;
    logic [7:0]  limit;
    logic        fixed_done;

    // pick up the kind on a field's first byte
    always_comb begin
        start    = (r_bytes == 4'd0);
        drop     = start && (i_item.func > vbd_pkg::KIND_VARLONG);
        kind     = start ? i_item.func : r_kind;
        n_cnt    = r_bytes + 4'd1;
        acc_base = start ? 64'd0 : r_acc;
    end

    // big-endian assembly and 7-bit group placement
    always_comb begin
        acc_fixed  = {acc_base[55:0], i_item.data_byte};
        fixed_done = ({1'b0, n_cnt} >= (5'd1 << kind[1:0]));
        shift      = 7'({3'b000, r_bytes} * 7'd7);
        shift_end  = {1'b0, shift} + 8'd7;
        limit      = (kind == vbd_pkg::KIND_VARINT) ? vbd_pkg::VARINT_SHIFT_LIMIT
                                                    : vbd_pkg::VARLONG_SHIFT_LIMIT;
        if (shift < 7'd64) begin
            group = {56'd0, i_item.data_byte & vbd_pkg::GROUP_MASK} << shift[5:0];
        end else begin
            group = 64'd0;
        end
        acc_var = acc_base | group;
        if (kind == vbd_pkg::KIND_VARINT) begin
            acc_var[63:32] = 32'd0;
        end
    end

    // result and next state
    always_comb begin
        o_res_valid     = 1'b0;
        o_result.value  = 64'd0;
        o_result.kind   = kind;
        o_result.status = vbd_pkg::STATUS_OK;
        n_acc           = r_acc;
        n_bytes         = r_bytes;
        n_kind          = r_kind;
        if (!drop) begin
            n_kind = kind;
            if (kind < vbd_pkg::KIND_VARINT) begin
                n_acc = acc_fixed;
                if (fixed_done) begin
                    o_res_valid    = 1'b1;
                    o_result.value = acc_fixed;
                end
            end else begin
                n_acc = acc_var;
                if ((i_item.data_byte & vbd_pkg::CONT_BIT) == 8'd0) begin
                    o_res_valid    = 1'b1;
                    o_result.value = acc_var;
                end else if (shift_end >= limit) begin
                    o_res_valid     = 1'b1;
                    o_result.status = vbd_pkg::STATUS_TOO_LONG;
                end
            end
            if (!o_res_valid && i_item.packet_end) begin
                o_res_valid     = 1'b1;
                o_result.status = vbd_pkg::STATUS_BOUNDS;
            end
            if (o_res_valid) begin
                n_acc   = 64'd0;
                n_bytes = 4'd0;
                n_kind  = vbd_pkg::KIND_U8;
            end else begin
                n_bytes = n_cnt;
            end
        end
    end

    // advance field state once per accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes <= 4'd0;
            r_kind  <= vbd_pkg::KIND_U8;
        end else if (i_advance) begin
            r_bytes <= n_bytes;
            r_kind  <= n_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_acc <= n_acc;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/varint_and_big_endian_field_decoder.sv */
// ----------------------------------------------------------------------------
// varint_and_big_endian_field_decoder: packet field decoder
// Big-endian unsigned fields and VarInt / VarLong decode, one byte a cycle while the output drains.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one packet byte per transaction in s_tdata, the field kind
//   in s_tuser (sampled only on a field's first byte), s_tlast on the last
//   byte of a packet.
//   Output stream: one transaction per completed or failed field, value in
//   m_tdata, kind and status in m_tuser.
//   Path: an accepted byte is held in the input register, then decoded
//   into the result register.
//   Throughput: one byte per cycle while the result register can drain; each
//   byte's shift/OR decode fits in the single stage between the two registers,
//   and the field state loop closes in that stage.
//   Reset: clears both register stages and closes any open field.
//   Stall: while the result register is full and m_tready is low, the
//   decode stage holds; the input register takes one more byte if it is empty,
//   then s_tready drops until the result leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module varint_and_big_endian_field_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  wire logic [2:0]  i_s_tuser,   // [2:0] func
    input  wire logic        i_s_tlast,   // packet_end
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [63:0]      o_m_tdata,   // [63:0] value
    output logic [4:0]       o_m_tuser    // [2:0] kind, [4:3] status
);

    vbd_pkg::t_in_item in_item;
    vbd_pkg::t_in_item held_item;
    vbd_pkg::t_result  result;
    vbd_pkg::t_result  out_result;
    logic              held_valid;
    logic              out_ready;
    logic              advance;
    logic              res_valid;

    // pack input fields
    always_comb begin
        in_item.data_byte  = i_s_tdata;
        in_item.func       = i_s_tuser;
        in_item.packet_end = i_s_tlast;
    end

    // input register
    vbd_pipe_reg #(
        .WIDTH (vbd_pkg::IN_W)
    ) u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_data  (in_item),
        .o_valid (held_valid),
        .i_ready (out_ready),
        .o_data  (held_item)
    );

    // decode the held byte when the result register has room
    assign advance = held_valid && out_ready;

    vbd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_item      (held_item),
        .o_res_valid (res_valid),
        .o_result    (result)
    );

    // result register
    vbd_pipe_reg #(
        .WIDTH (vbd_pkg::RES_W)
    ) u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (advance && res_valid),
        .o_ready (out_ready),
        .i_data  (result),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (out_result)
    );

    // unpack result fields
    assign o_m_tdata = out_result.value;
    assign o_m_tuser = {out_result.status, out_result.kind};

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for varint_and_big_endian_field_decoder
// Drives packet bytes through the input stream. A directed table covers the
// field extremes and the error cases, then random packets of well-formed
// fields follow, mixed with truncated, over-long and ignored bytes. Each
// accepted byte runs through a local decoder model. Every result
// transaction is compared field by field with the oldest pending
// expectation, under several sender and receiver idling phases.
// ----------------------------------------------------------------------------

module testbench;

    // undefined field kinds: dropped at a field start
    localparam logic [2:0] KIND_UNDEF_A = 3'd6;
    localparam logic [2:0] KIND_UNDEF_B = 3'd7;

    localparam int unsigned RANDOM_ITEMS = 1700;
    localparam int unsigned PHASE_LEN    = 200;
    localparam int unsigned HOLD_AT      = 850;
    localparam int unsigned HOLD_CYCLES  = 60;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    typedef enum int unsigned {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_phase;

    typedef struct {
        vbd_pkg::t_in_item item;
        bit                fixed;   // expectation typed in the table
        vbd_pkg::t_result  res;
    } t_stim;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = '0;   // [7:0] data_byte
    logic [2:0]  i_s_tuser  = '0;   // [2:0] func
    logic        i_s_tlast  = 1'b0; // packet_end
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [63:0] o_m_tdata;         // [63:0] value
    logic [4:0]  o_m_tuser;         // [2:0] kind, [4:3] status

    t_stim             byte_stream[$];
    vbd_pkg::t_result  pending_fields[$];
    int unsigned  n_sent      = 0;
    int unsigned  sent_q      = 0;
    int unsigned  n_errors    = 0;
    int unsigned  cycle_count = 0;
    int unsigned  hold_left   = 0;
    bit           hold_done   = 1'b0;

    // decoder model state
    logic [63:0]  fld_acc   = '0;
    logic [3:0]   fld_taken = '0;
    logic [2:0]   fld_kind  = '0;

    varint_and_big_endian_field_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_idle_phase phase_of(int unsigned n);
        return t_idle_phase'((n / PHASE_LEN) % 4);
    endfunction

    function automatic int unsigned sender_idle_pct(t_idle_phase p);
        case (p)
            IDLE_SENDER: return 66;
            IDLE_BOTH:   return 26;
            default:     return 0;
        endcase
    endfunction

    function automatic int unsigned receiver_stall_pct(t_idle_phase p);
        case (p)
            IDLE_RECEIVER: return 66;
            IDLE_BOTH:     return 26;
            default:       return 0;
        endcase
    endfunction

    function automatic void close_field();
        fld_acc   = '0;
        fld_taken = '0;
        fld_kind  = '0;
    endfunction

    // Decode one byte; return 1 when it completes or fails a field.
    function automatic bit decode_byte(input vbd_pkg::t_in_item it,
                                       output vbd_pkg::t_result r);
        logic [2:0]  k;
        int unsigned n;
        int unsigned shift;
        int unsigned limit;
        r = '0;
        if (fld_taken == 0) begin
            if (it.func > vbd_pkg::KIND_VARLONG)
                return 1'b0;
            fld_kind = it.func;
            fld_acc  = '0;
        end
        k = fld_kind;
        n = fld_taken + 1;
        r.kind = k;
        if (k < vbd_pkg::KIND_VARINT) begin
            fld_acc = {fld_acc[55:0], it.data_byte};
            if (n >= (1 << k)) begin
                r.value  = fld_acc;
                r.status = vbd_pkg::STATUS_OK;
                close_field();
                return 1'b1;
            end
        end else begin
            shift = 7 * (n - 1);
            limit = (k == vbd_pkg::KIND_VARINT) ? vbd_pkg::VARINT_SHIFT_LIMIT
                                                : vbd_pkg::VARLONG_SHIFT_LIMIT;
            if (shift < 64)
                fld_acc = fld_acc | ({56'd0, it.data_byte & vbd_pkg::GROUP_MASK} << shift);
            if (k == vbd_pkg::KIND_VARINT)
                fld_acc[63:32] = '0;
            if ((it.data_byte & vbd_pkg::CONT_BIT) == 0) begin
                r.value  = fld_acc;
                r.status = vbd_pkg::STATUS_OK;
                close_field();
                return 1'b1;
            end
            if (shift + 7 >= limit) begin
                r.status = vbd_pkg::STATUS_TOO_LONG;
                close_field();
                return 1'b1;
            end
        end
        if (it.packet_end) begin
            r.status = vbd_pkg::STATUS_BOUNDS;
            close_field();
            return 1'b1;
        end
        fld_taken = n[3:0];
        return 1'b0;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("ERROR at %0t: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        n_errors++;
    endtask

    task automatic add_byte(logic [7:0] data_b, logic [2:0] func, logic last_b);
        t_stim s;
        s.item.data_byte  = data_b;
        s.item.func       = func;
        s.item.packet_end = last_b;
        s.fixed           = 1'b0;
        s.res             = '0;
        byte_stream.push_back(s);
    endtask

    task automatic add_checked(logic [7:0] data_b, logic [2:0] func, logic last_b,
                               logic [63:0] value, logic [2:0] kind, logic [1:0] status);
        t_stim s;
        s.item.data_byte  = data_b;
        s.item.func       = func;
        s.item.packet_end = last_b;
        s.fixed           = 1'b1;
        s.res.value       = value;
        s.res.kind        = kind;
        s.res.status      = status;
        byte_stream.push_back(s);
    endtask

    // Input side: offer bytes, predict each accepted transaction.
    always @(posedge i_clk) begin
        vbd_pkg::t_result res;
        bit               got;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                got = decode_byte(byte_stream[n_sent].item, res);
                if (byte_stream[n_sent].fixed)
                    pending_fields.push_back(byte_stream[n_sent].res);
                else if (got)
                    pending_fields.push_back(res);
                n_sent++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (n_sent < byte_stream.size() &&
                    $urandom_range(99) >= sender_idle_pct(phase_of(n_sent))) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= byte_stream[n_sent].item.data_byte;
                    i_s_tuser  <= byte_stream[n_sent].item.func;
                    i_s_tlast  <= byte_stream[n_sent].item.packet_end;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
            sent_q <= n_sent;
        end
    end

    // Hold the receiver off once for a long stretch so the input side backs up
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && sent_q >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Output side: check each result transaction, drive ready.
    always @(posedge i_clk) begin
        vbd_pkg::t_result want;
        if (o_m_tvalid && i_m_tready) begin
            if (pending_fields.size() == 0) begin
                report_mismatch("result with no field pending", o_m_tdata, '0);
            end else begin
                want = pending_fields.pop_front();
                if (o_m_tdata !== want.value)
                    report_mismatch("value", o_m_tdata, want.value);
                if (o_m_tuser[2:0] !== want.kind)
                    report_mismatch("kind", {61'd0, o_m_tuser[2:0]}, {61'd0, want.kind});
                if (o_m_tuser[4:3] !== want.status)
                    report_mismatch("status", {62'd0, o_m_tuser[4:3]}, {62'd0, want.status});
            end
        end
        if (hold_left > 0 || (!hold_done && sent_q >= HOLD_AT)) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= receiver_stall_pct(phase_of(sent_q)));
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int unsigned counted;
        int unsigned len;
        int unsigned max_len;
        int unsigned cut;
        int unsigned ext;
        bit          too_long;
        logic [2:0]  k;
        logic [7:0]  data_b;
        logic        last_b;

        // Directed table
        add_checked(8'h00, vbd_pkg::KIND_U8, 1'b0, 64'h0, vbd_pkg::KIND_U8, vbd_pkg::STATUS_OK);
        add_checked(8'hFF, vbd_pkg::KIND_U8, 1'b1, 64'hFF, vbd_pkg::KIND_U8, vbd_pkg::STATUS_OK);
        add_checked(8'h12, vbd_pkg::KIND_U16, 1'b1, 64'h0, vbd_pkg::KIND_U16,
                    vbd_pkg::STATUS_BOUNDS);
        add_byte(8'h5A, KIND_UNDEF_A, 1'b0);
        add_byte(8'hA5, KIND_UNDEF_B, 1'b1);
        // u64 of all ones; func on later bytes must be ignored
        add_byte(8'hFF, vbd_pkg::KIND_U64, 1'b0);
        add_byte(8'hFF, vbd_pkg::KIND_U8, 1'b0);
        add_byte(8'hFF, KIND_UNDEF_B, 1'b0);
        add_byte(8'hFF, vbd_pkg::KIND_VARINT, 1'b0);
        add_byte(8'hFF, vbd_pkg::KIND_U16, 1'b0);
        add_byte(8'hFF, vbd_pkg::KIND_VARLONG, 1'b0);
        add_byte(8'hFF, KIND_UNDEF_A, 1'b0);
        add_checked(8'hFF, vbd_pkg::KIND_U32, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF,
                    vbd_pkg::KIND_U64, vbd_pkg::STATUS_OK);
        add_checked(8'h00, vbd_pkg::KIND_VARINT, 1'b0, 64'h0, vbd_pkg::KIND_VARINT,
                    vbd_pkg::STATUS_OK);
        // varint of five full groups: top group bits fall off past bit 31
        add_byte(8'hFF, vbd_pkg::KIND_VARINT, 1'b0);
        add_byte(8'hFF, vbd_pkg::KIND_U8, 1'b0);
        add_byte(8'hFF, vbd_pkg::KIND_U8, 1'b0);
        add_byte(8'hFF, vbd_pkg::KIND_U8, 1'b0);
        add_byte(8'h7F, vbd_pkg::KIND_U8, 1'b0);
        // too long wins over the end mark on the same byte
        add_byte(8'h80, vbd_pkg::KIND_VARINT, 1'b0);
        add_byte(8'h80, vbd_pkg::KIND_VARINT, 1'b0);
        add_byte(8'h80, vbd_pkg::KIND_VARINT, 1'b0);
        add_byte(8'h80, vbd_pkg::KIND_VARINT, 1'b0);
        add_checked(8'h80, vbd_pkg::KIND_VARINT, 1'b1, 64'h0, vbd_pkg::KIND_VARINT,
                    vbd_pkg::STATUS_TOO_LONG);
        add_checked(8'h81, vbd_pkg::KIND_VARLONG, 1'b1, 64'h0, vbd_pkg::KIND_VARLONG,
                    vbd_pkg::STATUS_BOUNDS);

        // Random packets: mostly whole fields, some truncated or over-long
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            if ($urandom_range(99) < 4) begin
                // dropped byte at a field boundary
                add_byte(8'($urandom), ($urandom_range(1) != 0) ? KIND_UNDEF_B : KIND_UNDEF_A,
                         1'($urandom_range(1)));
            end else begin
                k        = 3'($urandom_range(vbd_pkg::KIND_VARLONG));
                too_long = 1'b0;
                if (k < vbd_pkg::KIND_VARINT) begin
                    len = 1 << k;
                end else begin
                    max_len  = (k == vbd_pkg::KIND_VARINT) ? 5 : 10;
                    len      = ($urandom_range(3) == 0) ? max_len : $urandom_range(3, 1);
                    too_long = ($urandom_range(14) == 0);
                    if (too_long)
                        len = max_len;
                end
                cut = (len > 1 && $urandom_range(19) == 0) ? $urandom_range(len - 1, 1) : 0;
                for (int unsigned j = 1; j <= len; j++) begin
                    data_b = 8'($urandom);
                    ext    = $urandom_range(7);
                    if (ext == 0)
                        data_b = 8'hFF;
                    else if (ext == 1)
                        data_b = 8'h00;
                    if (k >= vbd_pkg::KIND_VARINT)
                        data_b[7] = too_long || (j < len);
                    last_b = (cut == j) ? 1'b1 : ((j == len) ? ($urandom_range(3) == 0) : 1'b0);
                    add_byte(data_b, (j == 1) ? k : 3'($urandom_range(7)), last_b);
                    counted++;
                    if (cut == j)
                        break;
                end
            end
        end

        // Reset, then run the stream
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (sent_q < byte_stream.size())
            @(posedge i_clk);
        while (pending_fields.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/vbd_pkg.sv
hw/rtl/vbd_pipe_reg.sv
hw/rtl/vbd_core.sv
hw/rtl/varint_and_big_endian_field_decoder.sv
tb/testbench.sv
